### design/psp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psp_pkg
// Types, codes and character constants shared by the format specifier parser.
// ---------------------------------------------------------------------------
package psp_pkg;

    localparam int NUMBER_BITS_DEFAULT = 16;
    localparam int RES_NUM_W           = 16;

    // parse phases
    localparam logic [2:0] PH_TEXT    = 3'd0;
    localparam logic [2:0] PH_FLAGS   = 3'd1;
    localparam logic [2:0] PH_WNUM    = 3'd2;
    localparam logic [2:0] PH_AFTERW  = 3'd3;
    localparam logic [2:0] PH_PSTART  = 3'd4;
    localparam logic [2:0] PH_PNUM    = 3'd5;
    localparam logic [2:0] PH_LEN     = 3'd6;
    localparam logic [2:0] PH_DISCARD = 3'd7;

    // result kinds
    localparam logic [2:0] KIND_LITERAL   = 3'd0;
    localparam logic [2:0] KIND_SPEC      = 3'd1;
    localparam logic [2:0] KIND_BAD_LEN   = 3'd2;
    localparam logic [2:0] KIND_BAD_TYPE  = 3'd3;
    localparam logic [2:0] KIND_TRUNCATED = 3'd4;

    // width and precision modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_STAR   = 2'd2;

    // length modifier codes
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_H    = 4'd1;
    localparam logic [3:0] LEN_HH   = 4'd2;
    localparam logic [3:0] LEN_L    = 4'd3;
    localparam logic [3:0] LEN_LL   = 4'd4;
    localparam logic [3:0] LEN_BIGL = 4'd5;
    localparam logic [3:0] LEN_Z    = 4'd6;
    localparam logic [3:0] LEN_J    = 4'd7;
    localparam logic [3:0] LEN_T    = 4'd8;
    localparam logic [3:0] LEN_BAD  = 4'd9;

    // flag bit positions
    localparam int FLAG_MINUS = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_SHARP = 3;
    localparam int FLAG_ZERO  = 4;

    localparam logic [7:0] CH_PERCENT = "%";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [7:0] CH_SHARP   = "#";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_ONE     = "1";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_H       = "h";
    localparam logic [7:0] CH_L       = "l";
    localparam logic [7:0] CH_BIGL    = "L";
    localparam logic [7:0] CH_Z       = "z";
    localparam logic [7:0] CH_J       = "j";
    localparam logic [7:0] CH_T       = "t";
    localparam logic [7:0] CH_AT      = "@";

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_mark;
    } psp_in_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           literal_char;
        logic [4:0]           flag_bits;
        logic [1:0]           width_mode;
        logic [RES_NUM_W-1:0] width_number;
        logic [1:0]           precision_mode;
        logic [RES_NUM_W-1:0] precision_number;
        logic [3:0]           length_code;
        logic [4:0]           type_code;
        logic                 string_done;
    } psp_out_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] flags;
        logic [1:0] width_mode;
        logic [1:0] precision_mode;
        logic [3:0] length;
    } psp_ctrl_t;

    typedef struct packed {
        logic       known;
        logic [4:0] code;
    } psp_type_t;

    function automatic psp_type_t type_lookup(input logic [7:0] c);
        psp_type_t r;
        r.known = 1'b1;
        case (c)
            CH_PERCENT: r.code = 5'd0;
            "d":        r.code = 5'd1;
            "i":        r.code = 5'd2;
            "u":        r.code = 5'd3;
            "f":        r.code = 5'd4;
            "F":        r.code = 5'd5;
            "e":        r.code = 5'd6;
            "E":        r.code = 5'd7;
            "g":        r.code = 5'd8;
            "G":        r.code = 5'd9;
            "x":        r.code = 5'd10;
            "X":        r.code = 5'd11;
            "o":        r.code = 5'd12;
            "s":        r.code = 5'd13;
            "c":        r.code = 5'd14;
            "p":        r.code = 5'd15;
            "a":        r.code = 5'd16;
            "A":        r.code = 5'd17;
            "n":        r.code = 5'd18;
            CH_AT:      r.code = 5'd19;
            default: begin
                r.known = 1'b0;
                r.code  = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic is_flag(input logic [7:0] c);
        return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
               (c == CH_SHARP) || (c == CH_ZERO);
    endfunction

    function automatic logic is_len(input logic [7:0] c);
        return (c == CH_H) || (c == CH_L) || (c == CH_BIGL) ||
               (c == CH_Z) || (c == CH_J) || (c == CH_T);
    endfunction

    function automatic logic [4:0] apply_flag(input logic [4:0] f, input logic [7:0] c);
        logic [4:0] r;
        r = f;
        case (c)
            CH_MINUS: begin
                r[FLAG_MINUS] = 1'b1;
                r[FLAG_ZERO]  = 1'b0;
            end
            CH_PLUS: begin
                r[FLAG_PLUS]  = 1'b1;
                r[FLAG_SPACE] = 1'b0;
            end
            CH_SPACE: begin
                if (!f[FLAG_PLUS]) r[FLAG_SPACE] = 1'b1;
            end
            CH_SHARP: r[FLAG_SHARP] = 1'b1;
            default: begin
                if (!f[FLAG_MINUS]) r[FLAG_ZERO] = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [3:0] apply_len(input logic [3:0] l, input logic [7:0] c);
        logic [3:0] r;
        case (c)
            CH_H:    r = (l == LEN_H) ? LEN_HH : (l == LEN_NONE) ? LEN_H : LEN_BAD;
            CH_L:    r = (l == LEN_L) ? LEN_LL : (l == LEN_NONE) ? LEN_L : LEN_BAD;
            CH_BIGL: r = (l == LEN_NONE) ? LEN_BIGL : LEN_BAD;
            CH_Z:    r = (l == LEN_NONE) ? LEN_Z : LEN_BAD;
            CH_J:    r = (l == LEN_NONE) ? LEN_J : LEN_BAD;
            default: r = (l == LEN_NONE) ? LEN_T : LEN_BAD;
        endcase
        return r;
    endfunction

endpackage

### design/psp_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psp_step
// Next-state and result logic for one format string byte.
// ---------------------------------------------------------------------------
module psp_step #(
    parameter int NUMBER_BITS = psp_pkg::NUMBER_BITS_DEFAULT
) (
    input  psp_pkg::psp_in_t        in_data,
    input  psp_pkg::psp_ctrl_t      ctrl_cur,
    input  logic [NUMBER_BITS-1:0]  width_cur,
    input  logic [NUMBER_BITS-1:0]  prec_cur,
    output psp_pkg::psp_ctrl_t      ctrl_next,
    output logic [NUMBER_BITS-1:0]  width_next,
    output logic [NUMBER_BITS-1:0]  prec_next,
    output logic                    res_valid,
    output psp_pkg::psp_out_t       res_data
);

    localparam int ACC_W = NUMBER_BITS + 4;

    logic [7:0]             c;
    logic                   done;
    logic                   is_digit;
    logic                   is_nz_digit;
    logic [NUMBER_BITS-1:0] acc_base;
    logic [ACC_W-1:0]       acc_ext;
    logic [ACC_W-1:0]       acc_sum;
    logic [NUMBER_BITS-1:0] acc_sat;
    logic [psp_pkg::RES_NUM_W-1:0] width_clamp;
    logic [psp_pkg::RES_NUM_W-1:0] prec_clamp;
    psp_pkg::psp_type_t     tinfo;
    psp_pkg::psp_ctrl_t     w;
    logic [NUMBER_BITS-1:0] wn;
    logic [NUMBER_BITS-1:0] pn;
    logic [1:0]             level;
    logic                   taken;
    logic [NUMBER_BITS-1:0] wn_pre;
    logic [NUMBER_BITS-1:0] pn_pre;

    assign c           = in_data.char_in;
    assign done        = in_data.end_mark;
    assign is_digit    = (c >= psp_pkg::CH_ZERO) && (c <= psp_pkg::CH_NINE);
    assign is_nz_digit = (c >= psp_pkg::CH_ONE) && (c <= psp_pkg::CH_NINE);
    assign tinfo       = psp_pkg::type_lookup(c);

    // shared saturating decimal accumulator: base * 10 + digit
    assign acc_base = (ctrl_cur.phase == psp_pkg::PH_WNUM) ? width_cur :
                      (ctrl_cur.phase == psp_pkg::PH_PNUM) ? prec_cur  : '0;
    assign acc_ext  = ACC_W'(acc_base);
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(c[3:0]);
    assign acc_sat  = (|acc_sum[ACC_W-1:NUMBER_BITS]) ? {NUMBER_BITS{1'b1}}
                                                      : acc_sum[NUMBER_BITS-1:0];

    always_comb begin
        w          = ctrl_cur;
        wn         = width_cur;
        pn         = prec_cur;
        level      = 2'd0;
        taken      = 1'b0;
        res_valid  = 1'b0;
        res_data   = '0;
        res_data.string_done = done;

        case (ctrl_cur.phase)
            psp_pkg::PH_TEXT: begin
                if (c != psp_pkg::CH_PERCENT) begin
                    res_valid             = 1'b1;
                    res_data.kind         = psp_pkg::KIND_LITERAL;
                    res_data.literal_char = c;
                end else begin
                    w       = '0;
                    wn      = '0;
                    pn      = '0;
                    w.phase = psp_pkg::PH_FLAGS;
                    if (done) begin
                        w.phase       = psp_pkg::PH_TEXT;
                        res_valid     = 1'b1;
                        res_data.kind = psp_pkg::KIND_TRUNCATED;
                    end
                end
            end
            psp_pkg::PH_DISCARD: begin
                if (done) w.phase = psp_pkg::PH_TEXT;
            end
            default: begin
                case (ctrl_cur.phase)
                    psp_pkg::PH_FLAGS: level = 2'd0;
                    psp_pkg::PH_WNUM: begin
                        if (is_digit) begin
                            wn    = acc_sat;
                            taken = 1'b1;
                        end
                        level = 2'd2;
                    end
                    psp_pkg::PH_AFTERW: level = 2'd2;
                    psp_pkg::PH_PSTART: begin
                        if (c == psp_pkg::CH_STAR) begin
                            w.precision_mode = psp_pkg::MODE_STAR;
                            w.phase          = psp_pkg::PH_LEN;
                            taken            = 1'b1;
                        end else begin
                            w.precision_mode = psp_pkg::MODE_NUMBER;
                            pn               = '0;
                            if (is_digit) begin
                                pn      = acc_sat;
                                w.phase = psp_pkg::PH_PNUM;
                                taken   = 1'b1;
                            end
                        end
                        level = 2'd3;
                    end
                    psp_pkg::PH_PNUM: begin
                        if (is_digit) begin
                            pn    = acc_sat;
                            taken = 1'b1;
                        end
                        level = 2'd3;
                    end
                    default: level = 2'd3;
                endcase

                if (!taken) begin
                    taken = 1'b1;
                    if (level == 2'd0 && psp_pkg::is_flag(c)) begin
                        w.flags = psp_pkg::apply_flag(w.flags, c);
                        w.phase = psp_pkg::PH_FLAGS;
                    end else if (level <= 2'd1 && c == psp_pkg::CH_STAR) begin
                        w.width_mode = psp_pkg::MODE_STAR;
                        w.phase      = psp_pkg::PH_AFTERW;
                    end else if (level <= 2'd1 && is_nz_digit) begin
                        w.width_mode = psp_pkg::MODE_NUMBER;
                        wn           = acc_sat;
                        w.phase      = psp_pkg::PH_WNUM;
                    end else if (level <= 2'd2 && c == psp_pkg::CH_DOT && !done) begin
                        w.phase = psp_pkg::PH_PSTART;
                    end else if (psp_pkg::is_len(c)) begin
                        w.length = psp_pkg::apply_len(w.length, c);
                        w.phase  = psp_pkg::PH_LEN;
                    end else begin
                        taken = 1'b0;
                    end
                end

                if (taken) begin
                    if (done) begin
                        res_valid     = 1'b1;
                        res_data.kind = (w.length == psp_pkg::LEN_BAD) ?
                                        psp_pkg::KIND_BAD_LEN : psp_pkg::KIND_TRUNCATED;
                        w  = '0;
                        wn = '0;
                        pn = '0;
                    end
                end else if (w.length == psp_pkg::LEN_BAD || !tinfo.known) begin
                    res_valid     = 1'b1;
                    res_data.kind = (w.length == psp_pkg::LEN_BAD) ?
                                    psp_pkg::KIND_BAD_LEN : psp_pkg::KIND_BAD_TYPE;
                    w       = '0;
                    wn      = '0;
                    pn      = '0;
                    w.phase = done ? psp_pkg::PH_TEXT : psp_pkg::PH_DISCARD;
                end else begin
                    res_valid                 = 1'b1;
                    res_data.kind             = psp_pkg::KIND_SPEC;
                    res_data.flag_bits        = w.flags;
                    res_data.width_mode       = w.width_mode;
                    res_data.width_number     = width_clamp;
                    res_data.precision_mode   = w.precision_mode;
                    res_data.precision_number = prec_clamp;
                    res_data.length_code      = w.length;
                    res_data.type_code        = tinfo.code;
                    w  = '0;
                    wn = '0;
                    pn = '0;
                end
            end
        endcase
    end

    // clamp or extend the working numbers to the result field width
    always_comb begin
        wn_pre = width_cur;
        pn_pre = prec_cur;
        if (ctrl_cur.phase == psp_pkg::PH_PSTART) pn_pre = '0;
    end

    generate
        if (NUMBER_BITS > psp_pkg::RES_NUM_W) begin : g_clamp
            assign width_clamp = (|wn_pre[NUMBER_BITS-1:psp_pkg::RES_NUM_W]) ?
                                 {psp_pkg::RES_NUM_W{1'b1}} :
                                 wn_pre[psp_pkg::RES_NUM_W-1:0];
            assign prec_clamp  = (|pn_pre[NUMBER_BITS-1:psp_pkg::RES_NUM_W]) ?
                                 {psp_pkg::RES_NUM_W{1'b1}} :
                                 pn_pre[psp_pkg::RES_NUM_W-1:0];
        end else begin : g_extend
            assign width_clamp = psp_pkg::RES_NUM_W'(wn_pre);
            assign prec_clamp  = psp_pkg::RES_NUM_W'(pn_pre);
        end
    endgenerate

    assign ctrl_next  = w;
    assign width_next = wn;
    assign prec_next  = pn;

endmodule

### design/printf_spec_parser_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// printf_spec_parser_core
// Decodes a printf-style format string one byte per transfer into literal,
// specification and error results.
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | psp_in_t  (char_in, end_mark)
//  m_      | out       | m_valid / m_ready | psp_out_t (kind .. string_done)
//
//  One byte per cycle while the result register can drain (m_ready);
//  a result appears in the cycle after its byte. The single result
//  register sets the rate: s_ready is high when it is empty or being drained in the same cycle.
//  Reset (aresetn low, synchronous) returns the parser to the text phase.
//  Bytes that produce no result still take one transfer each.
// ---------------------------------------------------------------------------
module printf_spec_parser_core #(
    parameter int NUMBER_BITS = psp_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  psp_pkg::psp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output psp_pkg::psp_out_t m_data
);

    psp_pkg::psp_ctrl_t     ctrl_reg;
    psp_pkg::psp_ctrl_t     ctrl_next;
    logic [NUMBER_BITS-1:0] width_reg;
    logic [NUMBER_BITS-1:0] width_next;
    logic [NUMBER_BITS-1:0] prec_reg;
    logic [NUMBER_BITS-1:0] prec_next;
    logic                   res_valid;
    psp_pkg::psp_out_t      res_data;
    logic                   m_valid_reg;
    psp_pkg::psp_out_t      m_data_reg;
    logic                   s_xfer;

    psp_step #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_step (
        .in_data    (s_data),
        .ctrl_cur   (ctrl_reg),
        .width_cur  (width_reg),
        .prec_cur   (prec_reg),
        .ctrl_next  (ctrl_next),
        .width_next (width_next),
        .prec_next  (prec_next),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '0;
            width_reg   <= '0;
            prec_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                ctrl_reg  <= ctrl_next;
                width_reg <= width_next;
                prec_reg  <= prec_next;
            end
            // advance the result register on a transfer, drop it when taken
            if (s_xfer) begin
                m_valid_reg <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && res_valid) begin
            m_data_reg <= res_data;
        end
    end

endmodule
